[design/rc4_pkg.sv]
// Shared constants, types and state codes for the RC4 stream cipher.
package rc4_pkg;

  localparam int ByteW       = 8;
  localparam int PermDepth   = 256;
  localparam int KeyMaxBytes = 256;
  localparam int KeyAddrW    = (KeyMaxBytes > 1) ? $clog2(KeyMaxBytes) : 1;
  localparam int KeyCntW     = $clog2(KeyMaxBytes + 1);

  localparam logic OpKey  = 1'b0;
  localparam logic OpData = 1'b1;

  typedef logic [ByteW-1:0]    byte_t;
  typedef logic [KeyAddrW-1:0] key_addr_t;
  typedef logic [KeyCntW-1:0]  key_cnt_t;

  typedef enum logic [2:0] {
    StIdle,
    StDatRdJ,
    StDatRdK,
    StDatOut,
    StKsRdN,
    StKsRdJ,
    StKsWrN,
    StKsWrJ
  } state_e;

  typedef struct packed {
    logic  clear;
    logic  we;
    byte_t waddr;
    byte_t wdata;
    logic  re;
    byte_t raddr;
  } perm_req_t;

  typedef struct packed {
    logic      we;
    key_addr_t waddr;
    byte_t     wdata;
    logic      re;
    key_addr_t raddr;
  } key_req_t;

endpackage

[design/rc4_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module rc4_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/rc4_perm_store.sv]
// Permutation store: RAM plus per-entry valid bits so unwritten entries read as identity.
module rc4_perm_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rc4_pkg::perm_req_t req_i,
  output rc4_pkg::byte_t     rdata_o
);

  logic [rc4_pkg::PermDepth-1:0] valid_q, valid_d;
  logic                          rd_valid_q;
  rc4_pkg::byte_t                rd_addr_q;
  rc4_pkg::byte_t                ram_rdata;

  rc4_ram #(
    .Width (rc4_pkg::ByteW),
    .Depth (rc4_pkg::PermDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.we),
    .waddr_i (req_i.waddr),
    .wdata_i (req_i.wdata),
    .re_i    (req_i.re),
    .raddr_i (req_i.raddr),
    .rdata_o (ram_rdata)
  );

  // A clear restores the identity permutation and wins over a write.
  always_comb begin
    valid_d = valid_q;
    if (req_i.clear) begin
      valid_d = '0;
    end else if (req_i.we) begin
      valid_d[req_i.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_addr_q <= req_i.raddr;
    end
  end

  assign rdata_o = rd_valid_q ? ram_rdata : rd_addr_q;

endmodule

[design/rc4_core.sv]
// Sequencer and datapath for key loading, the key schedule and keystream generation.
module rc4_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  rc4_pkg::byte_t     in_byte_i,
  input  logic               last_key_i,
  input  logic               out_free_i,
  output logic               res_valid_o,
  output rc4_pkg::byte_t     res_data_o,
  output rc4_pkg::perm_req_t perm_req_o,
  input  rc4_pkg::byte_t     perm_rdata_i,
  output rc4_pkg::key_req_t  key_req_o,
  input  rc4_pkg::byte_t     key_rdata_i
);

  rc4_pkg::state_e    state_q, state_d;
  rc4_pkg::byte_t     i_q, i_d;
  rc4_pkg::byte_t     j_q, j_d;
  rc4_pkg::byte_t     si_q, si_d;
  rc4_pkg::byte_t     sj_q, sj_d;
  rc4_pkg::byte_t     byte_q, byte_d;
  rc4_pkg::byte_t     n_q, n_d;
  logic               fwd_si_q, fwd_si_d;
  logic               fwd_ti_q, fwd_ti_d;
  logic               fwd_tj_q, fwd_tj_d;
  rc4_pkg::key_addr_t kpos_q, kpos_d;
  rc4_pkg::key_cnt_t  cnt_q, cnt_d;
  rc4_pkg::key_cnt_t  len_q, len_d;

  logic               accept;
  logic               acc_data;
  logic               acc_last;
  logic               sched_done;
  rc4_pkg::byte_t     si_cur;
  rc4_pkg::byte_t     ks;
  rc4_pkg::byte_t     i_next;
  rc4_pkg::byte_t     t_sum;
  rc4_pkg::byte_t     j_ks;
  rc4_pkg::key_cnt_t  kpos_inc;

  assign in_ready_o = (state_q == rc4_pkg::StIdle) ||
                      ((state_q == rc4_pkg::StDatOut) && out_free_i);
  assign accept     = in_valid_i && in_ready_o;
  assign acc_data   = accept && (opcode_i == rc4_pkg::OpData);
  assign acc_last   = accept && (opcode_i == rc4_pkg::OpKey) && last_key_i;
  assign sched_done = (n_q == rc4_pkg::byte_t'(rc4_pkg::PermDepth - 1));

  // The S[i] read for a new byte may coincide with the S[j] write of the previous one.
  assign si_cur   = fwd_si_q ? si_q : perm_rdata_i;
  assign ks       = fwd_tj_q ? si_q : (fwd_ti_q ? sj_q : perm_rdata_i);
  assign i_next   = rc4_pkg::byte_t'(i_q + 8'd1);
  assign t_sum    = rc4_pkg::byte_t'(si_q + perm_rdata_i);
  assign j_ks     = rc4_pkg::byte_t'(j_q + perm_rdata_i + key_rdata_i);
  assign kpos_inc = rc4_pkg::key_cnt_t'(kpos_q) + rc4_pkg::key_cnt_t'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rc4_pkg::StIdle, rc4_pkg::StDatOut: begin
        if (state_q == rc4_pkg::StIdle || out_free_i) begin
          if (acc_data) begin
            state_d = rc4_pkg::StDatRdJ;
          end else if (acc_last) begin
            state_d = rc4_pkg::StKsRdN;
          end else begin
            state_d = rc4_pkg::StIdle;
          end
        end
      end
      rc4_pkg::StDatRdJ: state_d = rc4_pkg::StDatRdK;
      rc4_pkg::StDatRdK: state_d = rc4_pkg::StDatOut;
      rc4_pkg::StKsRdN:  state_d = rc4_pkg::StKsRdJ;
      rc4_pkg::StKsRdJ:  state_d = rc4_pkg::StKsWrN;
      rc4_pkg::StKsWrN:  state_d = rc4_pkg::StKsWrJ;
      rc4_pkg::StKsWrJ:  state_d = sched_done ? rc4_pkg::StIdle : rc4_pkg::StKsRdN;
      default:           state_d = rc4_pkg::StIdle;
    endcase
  end

  always_comb begin
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    byte_d      = byte_q;
    n_d         = n_q;
    fwd_si_d    = fwd_si_q;
    fwd_ti_d    = fwd_ti_q;
    fwd_tj_d    = fwd_tj_q;
    kpos_d      = kpos_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    perm_req_o  = '0;
    key_req_o   = '0;
    res_valid_o = 1'b0;
    res_data_o  = ks ^ byte_q;

    unique case (state_q)
      rc4_pkg::StIdle: begin
      end
      rc4_pkg::StDatRdJ: begin
        si_d             = si_cur;
        j_d              = rc4_pkg::byte_t'(j_q + si_cur);
        perm_req_o.re    = 1'b1;
        perm_req_o.raddr = rc4_pkg::byte_t'(j_q + si_cur);
      end
      rc4_pkg::StDatRdK: begin
        sj_d             = perm_rdata_i;
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = i_q;
        perm_req_o.wdata = perm_rdata_i;
        perm_req_o.re    = 1'b1;
        perm_req_o.raddr = t_sum;
        fwd_ti_d         = (t_sum == i_q);
        fwd_tj_d         = (t_sum == j_q);
      end
      rc4_pkg::StDatOut: begin
        // Holding here repeats the same write, which is harmless.
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = j_q;
        perm_req_o.wdata = si_q;
        res_valid_o      = out_free_i;
      end
      rc4_pkg::StKsRdN: begin
        perm_req_o.re    = 1'b1;
        perm_req_o.raddr = n_q;
        key_req_o.re     = 1'b1;
        key_req_o.raddr  = kpos_q;
      end
      rc4_pkg::StKsRdJ: begin
        si_d             = perm_rdata_i;
        j_d              = j_ks;
        perm_req_o.re    = 1'b1;
        perm_req_o.raddr = j_ks;
      end
      rc4_pkg::StKsWrN: begin
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = n_q;
        perm_req_o.wdata = perm_rdata_i;
      end
      rc4_pkg::StKsWrJ: begin
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = j_q;
        perm_req_o.wdata = si_q;
        n_d              = rc4_pkg::byte_t'(n_q + 8'd1);
        if (kpos_inc >= len_q) begin
          kpos_d = '0;
        end else begin
          kpos_d = rc4_pkg::key_addr_t'(kpos_inc);
        end
        if (sched_done) begin
          i_d = '0;
          j_d = '0;
        end
      end
      default: begin
      end
    endcase

    if (acc_data) begin
      i_d              = i_next;
      byte_d           = in_byte_i;
      fwd_si_d         = (state_q == rc4_pkg::StDatOut) && (i_next == j_q);
      perm_req_o.re    = 1'b1;
      perm_req_o.raddr = i_next;
    end else if (accept) begin
      if (cnt_q < rc4_pkg::key_cnt_t'(rc4_pkg::KeyMaxBytes)) begin
        key_req_o.we    = 1'b1;
        key_req_o.waddr = cnt_q[rc4_pkg::KeyAddrW-1:0];
        key_req_o.wdata = in_byte_i;
        cnt_d           = cnt_q + rc4_pkg::key_cnt_t'(1);
      end
      if (last_key_i) begin
        len_d            = cnt_d;
        cnt_d            = '0;
        n_d              = '0;
        j_d              = '0;
        kpos_d           = '0;
        perm_req_o.clear = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rc4_pkg::StIdle;
      i_q     <= '0;
      j_q     <= '0;
      cnt_q   <= '0;
      n_q     <= '0;
      kpos_q  <= '0;
      len_q   <= rc4_pkg::key_cnt_t'(1);
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      kpos_q  <= kpos_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q     <= si_d;
    sj_q     <= sj_d;
    byte_q   <= byte_d;
    fwd_si_q <= fwd_si_d;
    fwd_ti_q <= fwd_ti_d;
    fwd_tj_q <= fwd_tj_d;
  end

  kc_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rc4_pkg::key_cnt_t'(rc4_pkg::KeyMaxBytes))
    else $error("key count passed the key store depth");

  kpos_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rc4_pkg::StKsRdN) |-> (rc4_pkg::key_cnt_t'(kpos_q) < len_q))
    else $error("key position reached the key length");

  sched_end_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rc4_pkg::StKsWrJ && sched_done)
      |=> (state_q == rc4_pkg::StIdle && i_q == '0 && j_q == '0))
    else $error("stream indices not cleared after the key schedule");

  sched_start_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_last |=> (n_q == '0 && j_q == '0 && kpos_q == '0 && len_q != '0))
    else $error("key schedule started from a bad state");

endmodule

[design/rc4_stream_cipher_top.sv]
// Top level of the RC4 stream cipher with stream ports and the result register.
//
// Usage: send key bytes with tuser low, one per transfer at one per cycle, and mark the
// final key byte with tlast. That transfer starts the key schedule of 256 rounds of
// four steps, each a read of the permutation entry and the key byte, a read of the
// partner entry, and two writes through the single write port; no input is taken
// meanwhile. Key bytes past 256 are dropped. Data bytes go in with tuser high, and each
// one returns one output byte, the input XOR the next keystream byte. A data byte takes
// three dependent accesses to the permutation memory, and its result passes the states
// StDatRdJ, StDatRdK and StDatOut and then the result register before it is offered on
// the output; the swap write of one byte overlaps the first read of the next, so a new
// data byte can be taken in the last state of the previous one, while the result
// register is free. After reset the permutation is the identity without any
// initialization pass, since every entry carries a valid bit.
module rc4_stream_cipher_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // in_byte[7:0]
  input  logic       s_axis_tuser_i,   // opcode[0]
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // out_byte[7:0]
);

  rc4_pkg::perm_req_t perm_req;
  rc4_pkg::byte_t     perm_rdata;
  rc4_pkg::key_req_t  key_req;
  rc4_pkg::byte_t     key_rdata;
  logic               res_valid;
  rc4_pkg::byte_t     res_data;
  logic               out_free;
  logic               m_valid_q, m_valid_d;
  rc4_pkg::byte_t     m_data_q, m_data_d;

  // The result register may be loaded when it is empty or drains in this cycle.
  assign out_free = !m_valid_q || m_axis_tready_i;

  rc4_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .opcode_i     (s_axis_tuser_i),
    .in_byte_i    (s_axis_tdata_i),
    .last_key_i   (s_axis_tlast_i),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_data_o   (res_data),
    .perm_req_o   (perm_req),
    .perm_rdata_i (perm_rdata),
    .key_req_o    (key_req),
    .key_rdata_i  (key_rdata)
  );

  rc4_perm_store u_perm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (perm_req),
    .rdata_o (perm_rdata)
  );

  // Key bytes are only read back during the schedule, after being written in this load.
  rc4_ram #(
    .Width (rc4_pkg::ByteW),
    .Depth (rc4_pkg::KeyMaxBytes)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_req.we),
    .waddr_i (key_req.waddr),
    .wdata_i (key_req.wdata),
    .re_i    (key_req.re),
    .raddr_i (key_req.raddr),
    .rdata_o (key_rdata)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (res_valid) begin
      m_valid_d = 1'b1;
      m_data_d  = res_data;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // A new result must never overwrite one that has not been transferred.
  no_overwrite_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!m_valid_q || m_axis_tready_i))
    else $error("result register overwritten before transfer");

endmodule

[tb/sv/tb_rc4_stream_cipher_top.sv]
// Self-checking testbench for the RC4 stream cipher top level with a keystream scoreboard.
`timescale 1ns / 100ps

module tb_rc4_stream_cipher_top;

  // Scoreboard that mirrors the cipher state. Every accepted input transfer is
  // applied to the local key or permutation, and every data byte queues the byte
  // that the block must return.
  class rc4_keystream_model;
    rc4_pkg::byte_t perm[rc4_pkg::PermDepth];
    rc4_pkg::byte_t key_bytes[rc4_pkg::KeyMaxBytes];
    int unsigned    key_len;
    rc4_pkg::byte_t idx_i;
    rc4_pkg::byte_t idx_j;
    rc4_pkg::byte_t cipher_q[$];
    int             errors;

    function new();
      for (int n = 0; n < rc4_pkg::PermDepth; n++) begin
        perm[n] = rc4_pkg::byte_t'(n);
      end
      foreach (key_bytes[n]) key_bytes[n] = '0;
      key_len = 0;
      idx_i   = '0;
      idx_j   = '0;
      errors  = 0;
    endfunction

    function void schedule_key(int unsigned len);
      rc4_pkg::byte_t j;
      rc4_pkg::byte_t t;
      int unsigned    kpos;
      j    = '0;
      kpos = 0;
      for (int n = 0; n < rc4_pkg::PermDepth; n++) begin
        perm[n] = rc4_pkg::byte_t'(n);
      end
      for (int n = 0; n < rc4_pkg::PermDepth; n++) begin
        j       = j + perm[n] + key_bytes[kpos];
        t       = perm[n];
        perm[n] = perm[j];
        perm[j] = t;
        kpos++;
        if (kpos >= len) kpos = 0;
      end
      idx_i = '0;
      idx_j = '0;
    endfunction

    function void note_transfer(logic op, rc4_pkg::byte_t value, logic last);
      rc4_pkg::byte_t t;
      rc4_pkg::byte_t ks;
      if (op == rc4_pkg::OpKey) begin
        // Bytes past the key store are dropped, but a last byte still counts.
        if (key_len < rc4_pkg::KeyMaxBytes) begin
          key_bytes[key_len] = value;
          key_len++;
        end
        if (last) begin
          schedule_key(key_len);
          key_len = 0;
        end
      end else begin
        idx_i       = idx_i + 8'd1;
        idx_j       = idx_j + perm[idx_i];
        t           = perm[idx_i];
        perm[idx_i] = perm[idx_j];
        perm[idx_j] = t;
        ks          = perm[rc4_pkg::byte_t'(perm[idx_i] + perm[idx_j])];
        cipher_q.push_back(ks ^ value);
      end
    endfunction

    function void check_byte(rc4_pkg::byte_t actual);
      rc4_pkg::byte_t want;
      if (cipher_q.size() == 0) begin
        $error("out_byte: no result expected, actual %02h", actual);
        errors++;
      end else begin
        want = cipher_q.pop_front();
        if (want !== actual) begin
          $error("out_byte: expected %02h, actual %02h", want, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return cipher_q.size();
    endfunction

    function void report_leftover();
      if (cipher_q.size() != 0) begin
        $error("out_byte: %0d expected results never arrived, next expected %02h",
               cipher_q.size(), cipher_q[0]);
        errors++;
      end
    endfunction
  endclass

  // Clock, reset and the stream interface of the block. Every input starts at
  // a known value at time zero.
  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = '0;   // in_byte[7:0]
  logic       s_axis_tuser_i  = 1'b0; // opcode[0]
  logic       s_axis_tlast_i  = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;         // out_byte[7:0]

  rc4_keystream_model cipher_model = new();

  // Idle rates in percent for the two sides, changed between phases.
  int unsigned tx_idle_pct = 37;
  int unsigned rx_idle_pct = 58;

  // A long hold-off of the receiver is requested by the stimulus through this
  // variable and then counted down by the receiver process itself, which notes
  // the request it has taken in its own copy.
  int unsigned rx_hold_req  = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;

  int unsigned items_sent = 0;

  rc4_stream_cipher_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: stalls at random, or for a whole hold-off stretch on request.
  always @(posedge clk_i) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_left = rx_hold_req;
      rx_hold_seen = rx_hold_req;
    end
    if (rx_hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_hold_left--;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Output monitor: every transfer on the master side is checked against the
  // oldest expected byte. Values read here are the ones held during the cycle.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      cipher_model.check_byte(m_axis_tdata_o);
    end
  end

  // Offers one item and waits for its transfer, then at random idles the sender.
  // It is always entered right after a rising edge. When no gap follows, tvalid
  // stays high into the next call without being lowered.
  task automatic send_item(logic op, rc4_pkg::byte_t value, logic last);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= op;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    cipher_model.note_transfer(op, value, last);
    items_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= rc4_pkg::byte_t'($urandom);
      s_axis_tuser_i  <= 1'($urandom);
      s_axis_tlast_i  <= 1'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Sends a key of the given length, the final byte marked with tlast. Now and
  // then a data byte is slipped into the middle of the load.
  task automatic load_key(int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      if (k > 0 && $urandom_range(99) < 6) begin
        send_item(rc4_pkg::OpData, rc4_pkg::byte_t'($urandom), 1'($urandom));
      end
      send_item(rc4_pkg::OpKey, rc4_pkg::byte_t'($urandom), k == len - 1);
    end
  endtask

  // Data bytes carry a random tlast, which the block must ignore.
  task automatic send_data(int unsigned count);
    repeat (count) send_item(rc4_pkg::OpData, rc4_pkg::byte_t'($urandom), 1'($urandom));
  endtask

  // The sender stops offering until every expected byte has come back.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (cipher_model.pending() != 0) @(posedge clk_i);
  endtask

  // Random messages: mostly a short key and a run of data bytes, sometimes a
  // full or overflowing key, sometimes more data under the current key.
  task automatic run_messages(int unsigned quota);
    int unsigned start;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        load_key($urandom_range(rc4_pkg::KeyMaxBytes + 1, rc4_pkg::KeyMaxBytes + 40));
      end else if (pick < 6) begin
        load_key(rc4_pkg::KeyMaxBytes);
      end else if (pick < 85) begin
        load_key($urandom_range(1, 16));
      end
      send_data($urandom_range(4, 40));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Data before any key runs on the identity permutation.
    send_item(rc4_pkg::OpData, 8'h00, 1'b1);
    send_item(rc4_pkg::OpData, 8'hFF, 1'b0);
    // A key of one byte, zero.
    send_item(rc4_pkg::OpKey, 8'h00, 1'b1);
    send_item(rc4_pkg::OpData, 8'h00, 1'b0);
    send_item(rc4_pkg::OpData, 8'hFF, 1'b1);
    send_item(rc4_pkg::OpData, 8'hA5, 1'b0);
    // A key load interrupted by data; the partial key stays stored.
    send_item(rc4_pkg::OpKey, 8'hFF, 1'b0);
    send_item(rc4_pkg::OpData, 8'h5A, 1'b1);
    send_item(rc4_pkg::OpKey, 8'h01, 1'b0);
    send_item(rc4_pkg::OpKey, 8'h80, 1'b1);
    send_data(3);
    // A short all-ones key followed by extreme data values.
    send_item(rc4_pkg::OpKey, 8'hFF, 1'b0);
    send_item(rc4_pkg::OpKey, 8'hFF, 1'b1);
    send_item(rc4_pkg::OpData, 8'hFF, 1'b0);
    send_item(rc4_pkg::OpData, 8'h00, 1'b0);
    send_item(rc4_pkg::OpData, 8'h80, 1'b1);
    send_item(rc4_pkg::OpData, 8'h01, 1'b0);

    // Key overflow: bytes past the store are dropped and the last byte still
    // starts the schedule at full length.
    load_key(rc4_pkg::KeyMaxBytes + 7);
    send_data(8);

    run_messages(450);

    tx_idle_pct = 58;
    rx_idle_pct = 37;
    run_messages(450);

    // No idling from here on. First the receiver holds off while data keeps
    // coming, so that the result path fills and the input stalls.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 300;
    send_data(40);
    drain_results();
    run_messages(450);

    drain_results();
    repeat (50) @(posedge clk_i);
    cipher_model.report_leftover();
    if (cipher_model.errors == 0) begin
      $display("tb_rc4_stream_cipher_top: PASS");
    end else begin
      $display("tb_rc4_stream_cipher_top: FAIL");
    end
    $finish;
  end

  // Watchdog, far above the slowest correct run.
  initial begin
    #8_000_000;
    $display("tb_rc4_stream_cipher_top: FAIL");
    $finish;
  end

endmodule
